### rtl/core/dsae_pkg.sv
// ----------------------------------------------------------------------------
// dsae_pkg
// shared types, word codes and helpers for the data stack alu engine
// ----------------------------------------------------------------------------
package dsae_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 256;
    localparam int unsigned DATA_W          = 64;

    // word codes
    localparam logic [4:0] KIND_LIT      = 5'd0;
    localparam logic [4:0] KIND_ADD      = 5'd1;
    localparam logic [4:0] KIND_SUB      = 5'd2;
    localparam logic [4:0] KIND_MUL      = 5'd3;
    localparam logic [4:0] KIND_DIVMOD   = 5'd4;
    localparam logic [4:0] KIND_NEG      = 5'd5;
    localparam logic [4:0] KIND_ABS      = 5'd6;
    localparam logic [4:0] KIND_ADDLIT   = 5'd7;
    localparam logic [4:0] KIND_EQ       = 5'd8;
    localparam logic [4:0] KIND_GT       = 5'd9;
    localparam logic [4:0] KIND_LT       = 5'd10;
    localparam logic [4:0] KIND_SKIPIF   = 5'd11;
    localparam logic [4:0] KIND_BRANCH   = 5'd12;
    localparam logic [4:0] KIND_SIGNBR   = 5'd13;
    localparam logic [4:0] KIND_XCHG     = 5'd14;
    localparam logic [4:0] KIND_XCHGSTK  = 5'd15;
    localparam logic [4:0] KIND_COPY     = 5'd16;
    localparam logic [4:0] KIND_COPYSTK  = 5'd17;
    localparam logic [4:0] KIND_DROP     = 5'd18;
    localparam logic [4:0] KIND_CLEAR    = 5'd19;
    localparam logic [4:0] KIND_DEPTH    = 5'd20;
    localparam logic [4:0] KIND_EXITTEST = 5'd21;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_FEW       = 3'd1;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ERR_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ERR_FULL      = 3'd4;

    // condition codes
    localparam logic [1:0] COND_GT = 2'd0;
    localparam logic [1:0] COND_EQ = 2'd1;
    localparam logic [1:0] COND_LT = 2'd2;

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [63:0] literal;
        logic [1:0]         condition;
    } item_t;

    typedef struct packed {
        logic signed [63:0] top_value;
        logic signed [63:0] second_value;
        logic [8:0]         stack_count;
        logic [2:0]         error_code;
        logic [2:0]         skip_count;
        logic               exit_request;
    } result_t;

    function automatic logic cond_holds(logic [1:0] c, logic [63:0] v);
        logic r;
        case (c)
            COND_GT: r = (v != 64'd0) && !v[63];
            COND_EQ: r = (v == 64'd0);
            COND_LT: r = v[63];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

### rtl/core/data_stack_alu_engine.sv
// ----------------------------------------------------------------------------
// data_stack_alu_engine
// executes one stack word per input item on a memory-backed 64-bit data stack
// ----------------------------------------------------------------------------
// The stack lives in one synchronous memory of STACK_ENTRIES x 64 bits with a
// single read port and a single write port, so one word is taken at a time.
// After acceptance a plain word runs through three operand reads (top, second,
// and the entry at the given depth), one decision step, two write slots, two
// reads that fetch the new top and second, and a final step that loads the
// output register. The next word is accepted only once the engine is back in
// idle, so one word never overlaps the next. A multiply adds a multiply phase
// (three 32x32 partial products through one shared multiplier); a divide/
// remainder adds a divide phase with one quotient bit per cycle.
// A new word is accepted while the previous result still waits on the output
// register; a result only holds the engine when the one before it is still
// stalled. There is no clearing pass: only entries below the fill count are
// ever read, so reset just empties the stack.
module data_stack_alu_engine #(
    parameter int unsigned STACK_ENTRIES = dsae_pkg::ENTRIES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  dsae_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output dsae_pkg::result_t result
);
    import dsae_pkg::*;

    localparam int unsigned CW = $clog2(STACK_ENTRIES + 1);
    localparam int unsigned AW = $clog2(STACK_ENTRIES);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RA   = 4'd1;   // read top
    localparam logic [3:0] ST_RB   = 4'd2;   // read second
    localparam logic [3:0] ST_RC   = 4'd3;   // read entry at depth
    localparam logic [3:0] ST_EX   = 4'd4;   // decide writes and new fill
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_WR1  = 4'd7;
    localparam logic [3:0] ST_WR2  = 4'd8;
    localparam logic [3:0] ST_F1   = 4'd9;   // fetch new top
    localparam logic [3:0] ST_F2   = 4'd10;  // fetch new second
    localparam logic [3:0] ST_F3   = 4'd11;  // build result word

    logic [3:0]    state_reg;
    logic [CW-1:0] fill_reg;

    // latched input word
    logic [4:0]  kind_reg;
    logic [63:0] lit_reg;
    logic [1:0]  cond_reg;

    // operands
    logic [63:0] a_reg;      // top
    logic [63:0] b_reg;      // second
    logic [63:0] top_reg;

    // write plan
    logic          w1_en_reg, w2_en_reg;
    logic [AW-1:0] w1_addr_reg, w2_addr_reg;
    logic [63:0]   w1_data_reg, w2_data_reg;
    logic [2:0]    err_reg, skip_reg;
    logic          exit_reg;

    // multiplier
    logic [1:0]  mstep_reg;
    logic [63:0] prod_reg, acc_reg;
    logic [31:0] mul_x, mul_y;

    // divider
    logic [5:0]  dcnt_reg;
    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic        qneg_reg, rneg_reg;
    logic [64:0] rem_sh, rem_diff;
    logic [63:0] rem_nx, quo_nx;
    logic        rem_ge;

    // output register
    logic    out_valid_reg;
    result_t out_reg;

    // stack memory
    logic [63:0]   stack_mem [STACK_ENTRIES];
    logic [63:0]   rd_q;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_q <= stack_mem[rd_addr];
    end

    // the stack-depth words (XCHGSTK, COPYSTK) work on the stack after the depth is popped
    logic          stk_form;
    logic [CW-1:0] depth_base;
    logic [63:0]   depth_val;

    assign stk_form   = (kind_reg == KIND_XCHGSTK) || (kind_reg == KIND_COPYSTK);
    assign depth_base = stk_form ? (fill_reg - CW'(1)) : fill_reg;
    assign depth_val  = stk_form ? a_reg : lit_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_RA, ST_F1: rd_addr = AW'(fill_reg - CW'(1));
            ST_RB, ST_F2, ST_F3: rd_addr = AW'(fill_reg - CW'(2));
            ST_RC: rd_addr = AW'(depth_base) - AW'(depth_val);
            default: rd_addr = '0;
        endcase
    end

    assign wr_en   = ((state_reg == ST_WR1) && w1_en_reg) || ((state_reg == ST_WR2) && w2_en_reg);
    assign wr_addr = (state_reg == ST_WR2) ? w2_addr_reg : w1_addr_reg;
    assign wr_data = (state_reg == ST_WR2) ? w2_data_reg : w1_data_reg;

    // ---------------- decision logic ----------------
    logic          p_w1_en, p_w2_en, p_mul, p_div;
    logic [AW-1:0] p_w1_addr, p_w2_addr;
    logic [63:0]   p_w1_data, p_w2_data;
    logic [2:0]    p_err, p_skip;
    logic          p_exit;
    logic [CW-1:0] p_fill;
    logic          full, has1, has2, lit_bad, lit_short, a_bad, a_short;
    logic [CW-1:0] n1;
    logic [63:0]   c_val;

    assign n1        = fill_reg - CW'(1);
    assign full      = fill_reg >= CW'(STACK_ENTRIES);
    assign has1      = fill_reg >= CW'(1);
    assign has2      = fill_reg >= CW'(2);
    assign lit_bad   = (lit_reg == 64'd0) || lit_reg[63];
    assign lit_short = 64'(fill_reg) < lit_reg;
    assign a_bad     = (a_reg == 64'd0) || a_reg[63];
    assign a_short   = 64'(n1) < a_reg;
    assign c_val     = rd_q;   // entry at depth, read in ST_RC

    always_comb
    begin
        p_w1_en   = 1'b0;
        p_w2_en   = 1'b0;
        p_w1_addr = '0;
        p_w2_addr = '0;
        p_w1_data = '0;
        p_w2_data = '0;
        p_mul     = 1'b0;
        p_div     = 1'b0;
        p_err     = ERR_NONE;
        p_skip    = 3'd0;
        p_exit    = 1'b0;
        p_fill    = fill_reg;
        unique case (kind_reg) inside
            KIND_LIT, KIND_DEPTH:
            begin
                if (full)
                begin
                    p_err = ERR_FULL;
                end
                else
                begin
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(fill_reg);
                    p_w1_data = (kind_reg == KIND_LIT) ? lit_reg : 64'(fill_reg);
                    p_fill    = fill_reg + CW'(1);
                end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_EQ, KIND_GT, KIND_LT:
            begin
                if (!has2)
                begin
                    p_err = ERR_FEW;
                end
                else
                begin
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(fill_reg - CW'(2));
                    p_fill    = n1;
                    case (kind_reg)
                        KIND_ADD: p_w1_data = b_reg + a_reg;
                        KIND_SUB: p_w1_data = b_reg - a_reg;
                        KIND_EQ:  p_w1_data = 64'(b_reg == a_reg);
                        KIND_GT:  p_w1_data = 64'($signed(b_reg) > $signed(a_reg));
                        KIND_LT:  p_w1_data = 64'($signed(b_reg) < $signed(a_reg));
                        default:  p_mul     = 1'b1;
                    endcase
                end
            end
            KIND_DIVMOD:
            begin
                if (!has2)
                begin
                    p_err = ERR_FEW;
                end
                else if (a_reg == 64'd0)
                begin
                    p_err  = ERR_DIV_ZERO;
                    p_fill = fill_reg - CW'(2);
                end
                else
                begin
                    p_div     = 1'b1;
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(fill_reg - CW'(2));
                    p_w2_en   = 1'b1;
                    p_w2_addr = AW'(n1);
                end
            end
            KIND_NEG, KIND_ABS, KIND_ADDLIT:
            begin
                if (!has1)
                begin
                    p_err = ERR_FEW;
                end
                else
                begin
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(n1);
                    case (kind_reg)
                        KIND_NEG: p_w1_data = 64'd0 - a_reg;
                        KIND_ABS: p_w1_data = mag(a_reg);
                        default:  p_w1_data = a_reg + lit_reg;
                    endcase
                end
            end
            KIND_SKIPIF, KIND_BRANCH, KIND_SIGNBR, KIND_EXITTEST:
            begin
                if (!has1)
                begin
                    p_err = ERR_FEW;
                end
                else
                begin
                    p_fill = n1;
                    case (kind_reg)
                        KIND_SKIPIF: p_skip = cond_holds(cond_reg, a_reg) ? 3'd0 : 3'd1;
                        KIND_BRANCH: p_skip = cond_holds(cond_reg, a_reg) ? 3'd0 : 3'd2;
                        KIND_SIGNBR: p_skip = a_reg[63] ? 3'd0
                                            : ((a_reg == 64'd0) ? 3'd2 : 3'd4);
                        default:     p_exit = cond_holds(cond_reg, a_reg);
                    endcase
                end
            end
            KIND_XCHG, KIND_COPY:
            begin
                if (lit_bad)
                begin
                    p_err = ERR_BAD_DEPTH;
                end
                else if (lit_short)
                begin
                    p_err = ERR_FEW;
                end
                else if (kind_reg == KIND_XCHG)
                begin
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(n1);
                    p_w1_data = c_val;
                    p_w2_en   = 1'b1;
                    p_w2_addr = AW'(fill_reg) - AW'(lit_reg);
                    p_w2_data = a_reg;
                end
                else if (full)
                begin
                    p_err = ERR_FULL;
                end
                else
                begin
                    p_w1_en   = 1'b1;
                    p_w1_addr = AW'(fill_reg);
                    p_w1_data = c_val;
                    p_fill    = fill_reg + CW'(1);
                end
            end
            KIND_XCHGSTK, KIND_COPYSTK:
            begin
                if (!has2)
                begin
                    p_err = ERR_FEW;
                end
                else
                begin
                    // depth stays popped whatever follows
                    p_fill = n1;
                    if ((kind_reg == KIND_XCHGSTK) && (a_reg == 64'd1))
                    begin
                        p_fill = n1;
                    end
                    else if (a_bad)
                    begin
                        p_err = ERR_BAD_DEPTH;
                    end
                    else if (a_short)
                    begin
                        p_err = ERR_FEW;
                    end
                    else if (kind_reg == KIND_XCHGSTK)
                    begin
                        p_w1_en   = 1'b1;
                        p_w1_addr = AW'(fill_reg - CW'(2));
                        p_w1_data = c_val;
                        p_w2_en   = 1'b1;
                        p_w2_addr = AW'(n1) - AW'(a_reg);
                        p_w2_data = b_reg;
                    end
                    else
                    begin
                        p_w1_en   = 1'b1;
                        p_w1_addr = AW'(n1);
                        p_w1_data = c_val;
                        p_fill    = fill_reg;
                    end
                end
            end
            KIND_DROP:
            begin
                if (!has1)
                begin
                    p_err = ERR_FEW;
                end
                else
                begin
                    p_fill = n1;
                end
            end
            KIND_CLEAR:
            begin
                p_fill = '0;
            end
            default:
            begin
                p_fill = fill_reg;
            end
        endcase
        if (p_err != ERR_NONE)
        begin
            p_skip = 3'd0;
            p_exit = 1'b0;
        end
    end

    // shared 32x32 multiplier, low 64 bits of the product only
    always_comb
    begin
        case (mstep_reg)
            2'd0:    begin mul_x = a_reg[31:0];  mul_y = b_reg[31:0];  end
            2'd1:    begin mul_x = a_reg[31:0];  mul_y = b_reg[63:32]; end
            default: begin mul_x = a_reg[63:32]; mul_y = b_reg[31:0];  end
        endcase
    end

    // one restoring divide step per cycle on magnitudes
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign rem_ge   = !rem_diff[64];
    assign rem_nx   = rem_ge ? rem_diff[63:0] : rem_sh[63:0];
    assign quo_nx   = {quo_reg[62:0], rem_ge};

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    logic out_free;
    assign out_free = !out_valid_reg || !result_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result word replaces one that leaves in the same cycle
            if ((state_reg == ST_F3) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= ST_RA;
                    end
                end
                ST_RA: state_reg <= ST_RB;
                ST_RB: state_reg <= ST_RC;
                ST_RC: state_reg <= ST_EX;
                ST_EX:
                begin
                    fill_reg <= p_fill;
                    if (p_mul)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else if (p_div)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_WR1;
                    end
                end
                ST_MUL:
                begin
                    if (mstep_reg == 2'd3)
                    begin
                        state_reg <= ST_WR1;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == 6'd63)
                    begin
                        state_reg <= ST_WR1;
                    end
                end
                ST_WR1: state_reg <= ST_WR2;
                ST_WR2: state_reg <= ST_F1;
                ST_F1:  state_reg <= ST_F2;
                ST_F2:  state_reg <= ST_F3;
                ST_F3:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                kind_reg <= item.kind;
                lit_reg  <= item.literal;
                cond_reg <= item.condition;
            end
            ST_RB: a_reg <= rd_q;
            ST_RC: b_reg <= rd_q;
            ST_EX:
            begin
                w1_en_reg   <= p_w1_en;
                w2_en_reg   <= p_w2_en;
                w1_addr_reg <= p_w1_addr;
                w2_addr_reg <= p_w2_addr;
                w1_data_reg <= p_w1_data;
                w2_data_reg <= p_w2_data;
                err_reg     <= p_err;
                skip_reg    <= p_skip;
                exit_reg    <= p_exit;
                mstep_reg   <= 2'd0;
                dcnt_reg    <= 6'd0;
                rem_reg     <= 64'd0;
                quo_reg     <= mag(b_reg);
                dvs_reg     <= mag(a_reg);
                qneg_reg    <= a_reg[63] ^ b_reg[63];
                rneg_reg    <= b_reg[63];
            end
            ST_MUL:
            begin
                prod_reg  <= mul_x * mul_y;
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg == 2'd1)
                begin
                    acc_reg <= prod_reg;
                end
                else if (mstep_reg == 2'd2)
                begin
                    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                end
                else if (mstep_reg == 2'd3)
                begin
                    w1_data_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                end
            end
            ST_DIV:
            begin
                rem_reg  <= rem_nx;
                quo_reg  <= quo_nx;
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    w1_data_reg <= qneg_reg ? (64'd0 - quo_nx) : quo_nx;
                    w2_data_reg <= rneg_reg ? (64'd0 - rem_nx) : rem_nx;
                end
            end
            ST_F2: top_reg <= (fill_reg >= CW'(1)) ? rd_q : 64'd0;
            ST_F3:
            begin
                if (out_free)
                begin
                    out_reg.top_value    <= top_reg;
                    out_reg.second_value <= (fill_reg >= CW'(2)) ? rd_q : 64'd0;
                    out_reg.stack_count  <= 9'(fill_reg);
                    out_reg.error_code   <= err_reg;
                    out_reg.skip_count   <= skip_reg;
                    out_reg.exit_request <= exit_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

### rtl/core/dsae_checker.sv
// ----------------------------------------------------------------------------
// dsae_checker
// port-level checks for the data stack alu engine
// ----------------------------------------------------------------------------
module dsae_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input dsae_pkg::result_t result
);
    import dsae_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // an error cancels skip and exit
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.error_code != ERR_NONE)
        |-> (result.skip_count == 3'd0) && !result.exit_request)
        else $error("skip or exit reported with error");

    // skip is 0, 1, 2 or 4
    a_skip_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.skip_count == 3'd0) || (result.skip_count == 3'd1)
                      || (result.skip_count == 3'd2) || (result.skip_count == 3'd4))
        else $error("illegal skip count");

    // exit test never reports a skip
    a_exit_noskip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.exit_request |-> (result.skip_count == 3'd0))
        else $error("exit with skip");

endmodule

bind data_stack_alu_engine dsae_checker u_dsae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### verif/tb_data_stack_alu_engine.sv
// ----------------------------------------------------------------------------
// tb_data_stack_alu_engine
// drives stack words into the engine, predicts each result and compares
// ----------------------------------------------------------------------------
// A queue of pending words is filled up front: a directed part that hits the
// special cases, then random programs that keep the stack mostly populated,
// with runs toward a full stack and back. A clocked driver presents words
// with random idle bursts; a clocked monitor applies random stall bursts and
// checks every result field against the prediction made at acceptance.
module tb_data_stack_alu_engine;
    import dsae_pkg::*;

    localparam int unsigned DEPTH_MAX = 256;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          TAIL_CYCLES = 200;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    data_stack_alu_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state
    logic [63:0] model_stack [DEPTH_MAX];
    int          model_fill;

    item_t   pending_words [$];
    result_t expected_results [$];
    int      mismatch_count;
    int      quiet_cycles;
    bit      idle_enabled;
    int      send_gap;
    int      stall_left;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic cond_true(logic [1:0] c, logic [63:0] v);
        logic r;
        r = 1'b0;
        if (c == COND_GT)
        begin
            r = (v != 64'd0) && !v[63];
        end
        else if (c == COND_EQ)
        begin
            r = (v == 64'd0);
        end
        else if (c == COND_LT)
        begin
            r = v[63];
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // executes one word on the predictor stack and returns the expected result
    function automatic result_t execute_word(item_t w);
        result_t     r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] m;
        logic [2:0]  err;
        logic [2:0]  skip;
        logic        ex;
        int          n;
        bit          full;
        err  = ERR_NONE;
        skip = 3'd0;
        ex   = 1'b0;
        n    = model_fill;
        full = (n >= DEPTH_MAX);
        case (w.kind)
            KIND_LIT, KIND_DEPTH:
            begin
                if (full)
                begin
                    err = ERR_FULL;
                end
                else
                begin
                    model_stack[n] = (w.kind == KIND_LIT) ? w.literal : 64'(n);
                    model_fill = n + 1;
                end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIVMOD, KIND_EQ, KIND_GT, KIND_LT:
            begin
                if (n < 2)
                begin
                    err = ERR_FEW;
                end
                else
                begin
                    a = model_stack[n-1];
                    b = model_stack[n-2];
                    case (w.kind)
                        KIND_ADD: begin model_stack[n-2] = b + a; model_fill = n - 1; end
                        KIND_SUB: begin model_stack[n-2] = b - a; model_fill = n - 1; end
                        KIND_MUL: begin model_stack[n-2] = b * a; model_fill = n - 1; end
                        KIND_DIVMOD:
                        begin
                            if (a == 64'd0)
                            begin
                                model_fill = n - 2;
                                err = ERR_DIV_ZERO;
                            end
                            else
                            begin
                                q = abs64(b) / abs64(a);
                                m = abs64(b) % abs64(a);
                                if (a[63] ^ b[63]) q = -q;
                                if (b[63]) m = -m;
                                model_stack[n-2] = q;
                                model_stack[n-1] = m;
                            end
                        end
                        default:
                        begin
                            if (w.kind == KIND_EQ)
                                model_stack[n-2] = 64'(b == a);
                            else if (w.kind == KIND_GT)
                                model_stack[n-2] = 64'($signed(b) > $signed(a));
                            else
                                model_stack[n-2] = 64'($signed(b) < $signed(a));
                            model_fill = n - 1;
                        end
                    endcase
                end
            end
            KIND_NEG, KIND_ABS, KIND_ADDLIT:
            begin
                if (n < 1)
                begin
                    err = ERR_FEW;
                end
                else
                begin
                    a = model_stack[n-1];
                    if (w.kind == KIND_NEG) a = -a;
                    else if (w.kind == KIND_ABS) a = abs64(a);
                    else a = a + w.literal;
                    model_stack[n-1] = a;
                end
            end
            KIND_SKIPIF, KIND_BRANCH, KIND_SIGNBR, KIND_EXITTEST:
            begin
                if (n < 1)
                begin
                    err = ERR_FEW;
                end
                else
                begin
                    a = model_stack[n-1];
                    model_fill = n - 1;
                    if (w.kind == KIND_SKIPIF)
                        skip = cond_true(w.condition, a) ? 3'd0 : 3'd1;
                    else if (w.kind == KIND_BRANCH)
                        skip = cond_true(w.condition, a) ? 3'd0 : 3'd2;
                    else if (w.kind == KIND_SIGNBR)
                        skip = a[63] ? 3'd0 : ((a == 64'd0) ? 3'd2 : 3'd4);
                    else
                        ex = cond_true(w.condition, a);
                end
            end
            KIND_XCHG, KIND_COPY:
            begin
                d = w.literal;
                if (d == 64'd0 || d[63])
                begin
                    err = ERR_BAD_DEPTH;
                end
                else if (64'(n) < d)
                begin
                    err = ERR_FEW;
                end
                else if (w.kind == KIND_XCHG)
                begin
                    a = model_stack[n-1];
                    model_stack[n-1] = model_stack[n-int'(d)];
                    model_stack[n-int'(d)] = a;
                end
                else if (full)
                begin
                    err = ERR_FULL;
                end
                else
                begin
                    model_stack[n] = model_stack[n-int'(d)];
                    model_fill = n + 1;
                end
            end
            KIND_XCHGSTK, KIND_COPYSTK:
            begin
                if (n < 2)
                begin
                    err = ERR_FEW;
                end
                else
                begin
                    // the depth operand stays popped whatever follows
                    d = model_stack[n-1];
                    n = n - 1;
                    model_fill = n;
                    if (w.kind == KIND_XCHGSTK && d == 64'd1)
                    begin
                    end
                    else if (d == 64'd0 || d[63])
                    begin
                        err = ERR_BAD_DEPTH;
                    end
                    else if (64'(n) < d)
                    begin
                        err = ERR_FEW;
                    end
                    else if (w.kind == KIND_XCHGSTK)
                    begin
                        a = model_stack[n-1];
                        model_stack[n-1] = model_stack[n-int'(d)];
                        model_stack[n-int'(d)] = a;
                    end
                    else
                    begin
                        model_stack[n] = model_stack[n-int'(d)];
                        model_fill = n + 1;
                    end
                end
            end
            KIND_DROP:
            begin
                if (n < 1) err = ERR_FEW;
                else model_fill = n - 1;
            end
            KIND_CLEAR:
            begin
                model_fill = 0;
            end
            default:
            begin
            end
        endcase
        if (err != ERR_NONE)
        begin
            skip = 3'd0;
            ex   = 1'b0;
        end
        n = model_fill;
        r.top_value    = (n >= 1) ? model_stack[n-1] : 64'd0;
        r.second_value = (n >= 2) ? model_stack[n-2] : 64'd0;
        r.stack_count  = 9'(n);
        r.error_code   = err;
        r.skip_count   = skip;
        r.exit_request = ex;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = 64'hffff_ffff_ffff_ffff;
            3: v = 64'd0;
            4: v = 64'($signed($urandom_range(0, 8)) - 4);
            5: v = 64'($urandom_range(0, 1000));
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    function automatic item_t make_word(logic [4:0] k, logic [63:0] lit, logic [1:0] c);
        item_t w;
        w.kind      = k;
        w.literal   = lit;
        w.condition = c;
        return w;
    endfunction

    // picks a random word, biased toward ones that do real work
    function automatic item_t random_word(int fill_hint);
        item_t w;
        int    sel;
        w = make_word(5'($urandom_range(0, 21)), rand64(), 2'($urandom_range(0, 3)));
        sel = $urandom_range(0, 99);
        if (sel < 30 || fill_hint < 2)
            w.kind = KIND_LIT;
        else if (sel < 36)
            w.kind = 5'($urandom_range(22, 31));
        if (w.kind == KIND_XCHG || w.kind == KIND_COPY)
        begin
            if ($urandom_range(0, 5) != 0)
                w.literal = 64'($urandom_range(1, 4));
        end
        if (w.kind == KIND_LIT && $urandom_range(0, 4) == 0)
            w.literal = 64'($urandom_range(0, 5));
        return w;
    endfunction

    initial begin : stimulus
        int fill_hint;
        int total;
        // directed: errors on empty stack, extremes, depth and divide cases, an unused code
        pending_words.push_back(make_word(KIND_ADD, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_DROP, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_XCHG, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_COPY, 64'h8000_0000_0000_0000, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'h8000_0000_0000_0000, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'hffff_ffff_ffff_ffff, COND_GT));
        pending_words.push_back(make_word(KIND_DIVMOD, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_NEG, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_DIVMOD, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'h7fff_ffff_ffff_ffff, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'd1, COND_GT));
        pending_words.push_back(make_word(KIND_XCHGSTK, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'hffff_ffff_ffff_fff9, COND_GT));
        pending_words.push_back(make_word(KIND_LIT, 64'd2, COND_GT));
        pending_words.push_back(make_word(KIND_DIVMOD, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_MUL, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_DEPTH, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_COPYSTK, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_SIGNBR, 64'd0, COND_GT));
        pending_words.push_back(make_word(KIND_SKIPIF, 64'd0, 2'd3));
        pending_words.push_back(make_word(KIND_CLEAR, 64'd0, COND_GT));
        pending_words.push_back(make_word(5'd31, 64'd0, COND_GT));
        // random part with a shadow fill estimate to steer the mix
        fill_hint = 0;
        total = 0;
        while (total < 1250)
        begin
            item_t w;
            if ($urandom_range(0, 199) == 0)
            begin
                // run to a full stack and beyond, then clear
                repeat (DEPTH_MAX + 3)
                    pending_words.push_back(make_word(KIND_LIT, rand64(), COND_GT));
                pending_words.push_back(make_word(KIND_DEPTH, 64'd0, COND_GT));
                pending_words.push_back(make_word(KIND_COPY, 64'd1, COND_GT));
                pending_words.push_back(make_word(KIND_XCHG, 64'd256, COND_GT));
                pending_words.push_back(make_word(KIND_CLEAR, 64'd0, COND_GT));
                fill_hint = 0;
                total += DEPTH_MAX + 7;
            end
            else
            begin
                w = random_word(fill_hint);
                if (w.kind == KIND_LIT || w.kind == KIND_DEPTH || w.kind == KIND_COPY)
                    fill_hint++;
                else if (w.kind == KIND_CLEAR)
                    fill_hint = 0;
                else if (w.kind != KIND_NEG && w.kind != KIND_ABS && w.kind != KIND_ADDLIT
                         && w.kind != KIND_XCHG && w.kind <= KIND_EXITTEST && fill_hint > 0)
                    fill_hint--;
                pending_words.push_back(w);
                total++;
            end
        end
    end

    // reset once at the start
    initial begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: presents pending words, holding each until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            item         <= '0;
            send_gap     = 0;
            idle_enabled = 1'b1;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(execute_word(item));
            end
            if (!item_valid || !item_stall)
            begin
                // last part of the run goes without idling
                if (pending_words.size() < 150)
                    idle_enabled = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (idle_enabled && $urandom_range(0, 15) == 0)
                begin
                    send_gap = $urandom_range(1, 17) - 1;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    item       <= pending_words.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall bursts on the result side, field by field checks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall   <= 1'b0;
            stall_left     = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %p", result);
                end
                else
                begin
                    result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (result.top_value !== exp_r.top_value
                        || result.second_value !== exp_r.second_value
                        || result.stack_count !== exp_r.stack_count
                        || result.error_code !== exp_r.error_code
                        || result.skip_count !== exp_r.skip_count
                        || result.exit_request !== exp_r.exit_request)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p actual %p", exp_r, result);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_enabled && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : finish_run
        quiet_cycles = 0;
        @(posedge rst_n);
        while ((pending_words.size() > 0 || item_valid || expected_results.size() > 0)
               && quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (mismatch_count == 0 && expected_results.size() == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
        end
        $finish;
    end

endmodule
